/* hdl/sorted_list_engine_core_assert.svh */
// assertion macros shared by the sorted list engine rtl
// depends on nothing; expects clk and rst_n in the including module
`ifndef SORTED_LIST_ENGINE_CORE_ASSERT_SVH
`define SORTED_LIST_ENGINE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SLE_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SLE_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* hdl/sle_pkg.sv */
// shared types, codes and width helpers for the sorted list engine
// no dependencies
package sle_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int INDEX_W      = 5;
    localparam int LIMIT_W      = 5;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_GET    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    // broadcast from the control to every cell
    typedef struct packed {
        logic                      cmp_en;
        logic                      ins_go;
        logic                      rem_go;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
    } cmd_t;

    // handed from a cell to its right neighbor
    typedef struct packed {
        logic valid;
        logic gt;
    } link_t;

    // compare flags reported back to the control
    typedef struct packed {
        logic eq;
        logic gt;
        logic hit;
    } flags_t;

    // bits for a count that can reach the capacity itself
    function automatic int count_width(input int cap);
        return $clog2(cap + 1);
    endfunction

    // common compare width for counts, limits and indexes
    function automatic int wide_width(input int cap);
        return ($clog2(cap + 1) > INDEX_W) ? $clog2(cap + 1) : INDEX_W;
    endfunction

endpackage

/* hdl/sle_cell.sv */
// one slot of the sorted list: holds an entry, compares it and shifts with neighbors
// depends on sle_pkg
module sle_cell #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF,
    parameter int SLOT     = 0
) (
    input  logic                               clk,
    input  sle_pkg::cmd_t                      cmd,
    input  logic [sle_pkg::count_width(CAPACITY)-1:0] count,
    input  sle_pkg::link_t                     left_link,
    input  logic signed [sle_pkg::VALUE_W-1:0] left_entry,
    input  logic signed [sle_pkg::VALUE_W-1:0] right_entry,
    output sle_pkg::link_t                     link_out,
    output logic signed [sle_pkg::VALUE_W-1:0] entry_out,
    output sle_pkg::flags_t                    flags,
    output logic signed [sle_pkg::VALUE_W-1:0] rd_data
);

    localparam int LW = sle_pkg::wide_width(CAPACITY);

    logic signed [sle_pkg::VALUE_W-1:0] entry_reg;
    logic signed [sle_pkg::VALUE_W-1:0] entry_next;
    logic                               gt_reg;
    logic                               eq_reg;
    logic                               hit_reg;
    logic                               valid;

    // slot holds a live entry when it sits below the count
    assign valid = LW'(count) > LW'(SLOT);

    // first phase: compare against the transaction value
    always_ff @(posedge clk)
    begin
        if (cmd.cmp_en)
        begin
            gt_reg  <= valid && (entry_reg > cmd.value);
            eq_reg  <= valid && (entry_reg == cmd.value);
            hit_reg <= valid && (LW'(cmd.index) == LW'(SLOT));
        end
    end

    // second phase: shift right on insert, shift left on remove
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins_go && left_link.gt)
        begin
            entry_next = left_entry;
        end
        else if (cmd.ins_go && (gt_reg || (!valid && left_link.valid)))
        begin
            entry_next = cmd.value;
        end
        else if (cmd.rem_go && (gt_reg || eq_reg))
        begin
            entry_next = right_entry;
        end
    end

    // entry storage, undefined until written
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign link_out  = '{valid: valid, gt: gt_reg};
    assign entry_out = entry_reg;
    assign flags     = '{eq: eq_reg, gt: gt_reg, hit: hit_reg};
    assign rd_data   = hit_reg ? entry_reg : '0;

endmodule

/* hdl/sorted_list_engine_core.sv */
// sorted list engine top: control, count register and the row of list cells
// depends on sle_pkg, sle_cell and sorted_list_engine_core_assert.svh
// each transaction is registered in order: compare first, then shift and report
// one transaction at a time: start is ignored while busy, which is high for the cycle after an accepted start
// reset clears the count, busy and done and sets the limit register to 16
// results cannot be stalled: each is valid for the single cycle that done is high
`include "sorted_list_engine_core_assert.svh"

module sorted_list_engine_core #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         mode,
    input  logic signed [sle_pkg::VALUE_W-1:0] value,
    input  logic [sle_pkg::INDEX_W-1:0]        index,
    input  logic                               cfg_we,
    input  logic [sle_pkg::LIMIT_W-1:0]        cfg_data,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [3:0]                         position,
    output logic signed [sle_pkg::VALUE_W-1:0] read_value,
    output logic [4:0]                         count
);

    localparam int CW = sle_pkg::count_width(CAPACITY);
    localparam int LW = sle_pkg::wide_width(CAPACITY);

    logic                               busy_reg;
    logic                               done_reg;
    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic [sle_pkg::LIMIT_W-1:0]        limit_reg;
    sle_pkg::mode_t                     mode_reg;
    logic signed [sle_pkg::VALUE_W-1:0] value_reg;
    sle_pkg::status_t                   status_reg;
    sle_pkg::status_t                   status_next;
    logic [LW-1:0]                      pos_reg;
    logic [LW-1:0]                      pos_next;
    logic signed [sle_pkg::VALUE_W-1:0] rd_reg;
    logic signed [sle_pkg::VALUE_W-1:0] rd_next;

    sle_pkg::cmd_t                      cmd;
    sle_pkg::link_t                     link_arr  [CAPACITY];
    logic signed [sle_pkg::VALUE_W-1:0] entry_arr [CAPACITY];
    sle_pkg::flags_t                    flag_arr  [CAPACITY];
    logic signed [sle_pkg::VALUE_W-1:0] rd_arr    [CAPACITY];

    logic                               accept;
    logic                               full;
    logic                               found;
    logic                               any_hit;
    logic [LW-1:0]                      eff_limit;
    logic [LW-1:0]                      eq_pos;
    logic [LW-1:0]                      ins_pos;
    logic signed [sle_pkg::VALUE_W-1:0] rd_or;

    assign accept = start && !busy_reg;

    // limit clamped to the physical capacity, full check on the current count
    assign eff_limit = (LW'(limit_reg) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(limit_reg);
    assign full      = LW'(count_reg) >= eff_limit;

    // reduce cell flags: first equal, first greater, get read-out
    always_comb
    begin
        found   = 1'b0;
        any_hit = 1'b0;
        eq_pos  = '0;
        ins_pos = LW'(count_reg);
        rd_or   = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (flag_arr[i].eq)
            begin
                eq_pos = LW'(i);
            end
            if (flag_arr[i].gt)
            begin
                ins_pos = LW'(i);
            end
            found   = found | flag_arr[i].eq;
            any_hit = any_hit | flag_arr[i].hit;
            rd_or   = rd_or | rd_arr[i];
        end
    end

    // broadcast to the cells: compare on accept, shift in the following cycle
    always_comb
    begin
        cmd.cmp_en = accept;
        cmd.ins_go = busy_reg && (mode_reg == sle_pkg::MODE_INSERT) && !full;
        cmd.rem_go = busy_reg && (mode_reg == sle_pkg::MODE_REMOVE) && found;
        cmd.value  = busy_reg ? value_reg : value;
        cmd.index  = index;
    end

    // result and count update for the transaction while busy is high
    always_comb
    begin
        status_next = sle_pkg::ST_OK;
        pos_next    = '0;
        rd_next     = '0;
        count_next  = count_reg;
        unique case (mode_reg)
            sle_pkg::MODE_INSERT:
            begin
                if (full)
                begin
                    status_next = sle_pkg::ST_FULL;
                end
                else
                begin
                    pos_next   = ins_pos;
                    count_next = count_reg + CW'(1);
                end
            end
            sle_pkg::MODE_REMOVE,
            sle_pkg::MODE_SEARCH:
            begin
                if (!found)
                begin
                    status_next = sle_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    pos_next = eq_pos;
                    if (mode_reg == sle_pkg::MODE_REMOVE)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            sle_pkg::MODE_GET:
            begin
                if (!any_hit)
                begin
                    status_next = sle_pkg::ST_RANGE;
                end
                else
                begin
                    rd_next = rd_or;
                end
            end
            default:
            begin
                status_next = sle_pkg::ST_OK;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
            limit_reg <= sle_pkg::LIMIT_W'(16);
        end
        else
        begin
            busy_reg <= accept;
            done_reg <= busy_reg;
            if (busy_reg)
            begin
                count_reg <= count_next;
            end
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // transaction and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= sle_pkg::mode_t'(mode);
            value_reg <= value;
        end
        if (busy_reg)
        begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            rd_reg     <= rd_next;
        end
    end

    // row of list cells
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        sle_pkg::link_t                     left_link;
        logic signed [sle_pkg::VALUE_W-1:0] left_entry;
        logic signed [sle_pkg::VALUE_W-1:0] right_entry;

        if (g == 0)
        begin : g_head
            assign left_link  = '{valid: 1'b1, gt: 1'b0};
            assign left_entry = '0;
        end
        else
        begin : g_body
            assign left_link  = link_arr[g-1];
            assign left_entry = entry_arr[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign right_entry = entry_arr[g];
        end
        else
        begin : g_inner
            assign right_entry = entry_arr[g+1];
        end

        sle_cell #(
            .CAPACITY (CAPACITY),
            .SLOT     (g)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .count       (count_reg),
            .left_link   (left_link),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .link_out    (link_arr[g]),
            .entry_out   (entry_arr[g]),
            .flags       (flag_arr[g]),
            .rd_data     (rd_arr[g])
        );
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign status     = status_reg;
    assign position   = pos_reg[3:0];
    assign read_value = rd_reg;
    assign count      = LW'(count_reg) > LW'(0) ? 5'(LW'(count_reg)) : 5'd0;

    // checks
    `SLE_ASSERT_NEXT(a_done_follows, busy_reg, done_reg, "done missing after busy")
    `SLE_ASSERT_NEXT(a_single_done, done_reg, !done_reg, "done held for two cycles")
    `SLE_ASSERT_NOW(a_count_bound, 1'b1, LW'(count_reg) <= LW'(CAPACITY), "count above capacity")
    `SLE_ASSERT_NEXT(a_insert_grows, cmd.ins_go, count_reg == $past(count_reg) + CW'(1), "insert count")

endmodule

/* tb/sorted_list_engine_core_test.sv */
// self-checking bench for sorted_list_engine_core: directed corners, then random list traffic
// depends on sle_pkg and the sorted_list_engine_core rtl; a shadow list predicts every result
module sorted_list_engine_core_test;

    localparam int CAP       = sle_pkg::CAPACITY_DEF;
    localparam int STALL_MAX = 4000;
    localparam int SETTLE    = 4;
    localparam int PHASES    = 10;
    localparam int PHASE_OPS = 190;

    typedef enum logic [1:0] { JOB_OP, JOB_LIMIT, JOB_DRAIN } job_kind_t;

    typedef struct {
        job_kind_t          kind;
        sle_pkg::mode_t     op;
        logic signed [31:0] value;
        logic [4:0]         index;
        logic [4:0]         limit;
    } job_t;

    typedef struct packed {
        sle_pkg::status_t   status;
        logic [3:0]         position;
        logic signed [31:0] read_value;
        logic [4:0]         count;
    } outcome_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         mode = sle_pkg::MODE_INSERT;
    logic signed [31:0] value = '0;
    logic [4:0]         index = '0;
    logic               cfg_we = 1'b0;
    logic [4:0]         cfg_data = '0;
    logic               done;
    logic [1:0]         status;
    logic [3:0]         position;
    logic signed [31:0] read_value;
    logic [4:0]         count;

    // shadow of the list and its limit
    logic signed [31:0] shadow_list [CAP];
    int                 shadow_len = 0;
    int                 limit_reg = 16;

    job_t               job_queue [$];
    outcome_t           expected_results [$];
    logic signed [31:0] value_pool [$];
    job_t               cur_job;
    job_t               head;
    int                 phase_limits [PHASES] = '{16, 1, 31, 0, 5, 17, 2, 12, 16, 9};

    int gap_left = 0;
    int burst_left = 0;
    int quiet = 0;
    int in_flight = 0;
    bit all_sent = 1'b0;
    int fail_count = 0;
    int result_count = 0;
    int accepted = 0;
    int limit_writes = 0;
    int stall = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    sorted_list_engine_core #(
        .CAPACITY(CAP)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .value(value),
        .index(index),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .done(done),
        .status(status),
        .position(position),
        .read_value(read_value),
        .count(count)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // apply one operation to the shadow list and return its result
    function automatic outcome_t list_apply(input sle_pkg::mode_t op,
                                            input logic signed [31:0] v,
                                            input logic [4:0] idx);
        outcome_t o;
        int       eff;
        int       p;
        int       i;
        o.status     = sle_pkg::ST_OK;
        o.position   = '0;
        o.read_value = '0;
        eff = (limit_reg > CAP) ? CAP : limit_reg;
        case (op)
            sle_pkg::MODE_INSERT:
            begin
                if (shadow_len >= eff)
                    o.status = sle_pkg::ST_FULL;
                else
                begin
                    // first entry strictly greater, so equal values keep arrival order
                    p = shadow_len;
                    for (i = shadow_len - 1; i >= 0; i--)
                        if (shadow_list[i] > v)
                            p = i;
                    for (i = shadow_len; i > p; i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[p] = v;
                    shadow_len++;
                    o.position = p[3:0];
                end
            end
            sle_pkg::MODE_REMOVE, sle_pkg::MODE_SEARCH:
            begin
                p = -1;
                for (i = shadow_len - 1; i >= 0; i--)
                    if (shadow_list[i] == v)
                        p = i;
                if (p < 0)
                    o.status = sle_pkg::ST_NOT_FOUND;
                else
                begin
                    o.position = p[3:0];
                    if (op == sle_pkg::MODE_REMOVE)
                    begin
                        for (i = p; i < shadow_len - 1; i++)
                            shadow_list[i] = shadow_list[i + 1];
                        shadow_len--;
                    end
                end
            end
            sle_pkg::MODE_GET:
            begin
                if (idx >= shadow_len)
                    o.status = sle_pkg::ST_RANGE;
                else
                    o.read_value = shadow_list[idx];
            end
        endcase
        o.count = shadow_len[4:0];
        return o;
    endfunction

    task automatic note_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
        fail_count++;
        $display("mismatch at result %0d, %s: got %0d, expected %0d",
                 result_count, what, got, want);
    endtask

    task automatic push_op(input sle_pkg::mode_t op, input logic signed [31:0] v,
                           input logic [4:0] idx);
        job_t j;
        j.kind  = JOB_OP;
        j.op    = op;
        j.value = v;
        j.index = idx;
        j.limit = '0;
        job_queue.push_back(j);
        // remember recent inserts so removes and searches hit often
        if (op == sle_pkg::MODE_INSERT)
        begin
            value_pool.push_back(v);
            if (value_pool.size() > 24)
                value_pool.delete(0);
        end
    endtask

    task automatic push_ctrl(input job_kind_t kind, input logic [4:0] lim);
        job_t j;
        j.kind  = kind;
        j.op    = sle_pkg::MODE_INSERT;
        j.value = '0;
        j.index = '0;
        j.limit = lim;
        job_queue.push_back(j);
    endtask

    // mix of recent values, a small cluster around zero, extremes and anything
    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 && value_pool.size() > 0)
            return value_pool[$urandom_range(0, value_pool.size() - 1)];
        if (r < 65)
            return int'($urandom_range(0, 12)) - 6;
        if (r < 75)
            return (r & 1) ? 32'sh7fff_ffff - (r % 3) : 32'sh8000_0000 + (r % 3);
        return $urandom();
    endfunction

    task automatic push_random(input int insert_weight);
        int r;
        r = $urandom_range(0, 99);
        if (r < insert_weight)
            push_op(sle_pkg::MODE_INSERT, pick_value(), 5'($urandom_range(0, 31)));
        else if (r < insert_weight + 25)
            push_op(sle_pkg::MODE_REMOVE, pick_value(), 5'($urandom_range(0, 31)));
        else if (r < insert_weight + 45)
            push_op(sle_pkg::MODE_SEARCH, pick_value(), 5'($urandom_range(0, 31)));
        else if ($urandom_range(0, 3) == 0)
            push_op(sle_pkg::MODE_GET, pick_value(), 5'($urandom_range(0, 31)));
        else
            push_op(sle_pkg::MODE_GET, pick_value(), 5'($urandom_range(0, 16)));
    endtask

    // driver: one transaction at a time from job_queue, bursts with gaps
    always @(posedge clk)
    begin
        logic       nx_start;
        logic       nx_we;
        logic [4:0] nx_data;
        if (rst_n)
        begin
            nx_start = start && busy;
            nx_we    = 1'b0;
            nx_data  = cfg_data;
            // limit write lands at this edge
            if (cfg_we)
            begin
                limit_reg = cfg_data;
                limit_writes++;
            end
            if (done)
                in_flight--;
            // transaction taken: predict its result
            if (start && !busy)
            begin
                expected_results.push_back(list_apply(sle_pkg::mode_t'(cur_job.op),
                                                      cur_job.value, cur_job.index));
                in_flight++;
                accepted++;
            end
            quiet = (!start && in_flight == 0 && !cfg_we) ? quiet + 1 : 0;
            // pick the next transaction, or settle before a limit write or drain
            if (!nx_start && job_queue.size() != 0)
            begin
                head = job_queue[0];
                if (head.kind == JOB_OP)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    else
                    begin
                        cur_job = job_queue.pop_front();
                        nx_start = 1'b1;
                        mode  <= cur_job.op;
                        value <= cur_job.value;
                        index <= cur_job.index;
                        if (burst_left > 0)
                            burst_left--;
                        else
                        begin
                            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                                     : $urandom_range(0, 12);
                            gap_left   = $urandom_range(1, 15);
                        end
                    end
                end
                else if (quiet >= SETTLE)
                begin
                    if (head.kind == JOB_LIMIT)
                    begin
                        nx_we   = 1'b1;
                        nx_data = head.limit;
                    end
                    job_queue.delete(0);
                    quiet = 0;
                end
            end
            start    <= nx_start;
            cfg_we   <= nx_we;
            cfg_data <= nx_data;
            all_sent <= (job_queue.size() == 0 && !nx_start && !nx_we && in_flight == 0);
        end
    end

    // monitor: check each result against the oldest prediction, plus the watchdog
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n)
        begin
            if ((start && !busy) || done || cfg_we)
                stall = 0;
            else
                stall++;
            if (stall >= STALL_MAX)
            begin
                $display("watchdog: no transaction for %0d cycles", stall);
                $display("sorted_list_engine_core test failed");
                $finish;
            end
            if (done)
            begin
                result_count++;
                if (expected_results.size() == 0)
                    note_mismatch("result with none predicted, count", count, 0);
                else
                begin
                    want = expected_results.pop_front();
                    status_seen[want.status]++;
                    if (status !== want.status)
                        note_mismatch("status", status, want.status);
                    if (position !== want.position)
                        note_mismatch("position", position, want.position);
                    if (read_value !== want.read_value)
                        note_mismatch("read_value", read_value, want.read_value);
                    if (count !== want.count)
                        note_mismatch("count", count, want.count);
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int ph;
        int n;
        // empty list corners under the reset limit
        push_op(sle_pkg::MODE_GET, 0, 0);
        push_op(sle_pkg::MODE_REMOVE, 5, 31);
        push_op(sle_pkg::MODE_SEARCH, 0, 0);
        push_op(sle_pkg::MODE_INSERT, 32'sh7fff_ffff, 0);
        push_op(sle_pkg::MODE_INSERT, 32'sh8000_0000, 5'h1f);
        push_op(sle_pkg::MODE_INSERT, 0, 0);
        // equal value lands behind the first one
        push_op(sle_pkg::MODE_INSERT, 0, 0);
        push_op(sle_pkg::MODE_INSERT, -1, 0);
        push_op(sle_pkg::MODE_SEARCH, 0, 0);
        push_op(sle_pkg::MODE_GET, 0, 5'd31);
        push_op(sle_pkg::MODE_GET, 0, 0);
        push_op(sle_pkg::MODE_GET, 32'shffff_ffff, 4);
        push_op(sle_pkg::MODE_GET, 0, 5);
        push_op(sle_pkg::MODE_REMOVE, 0, 0);
        push_op(sle_pkg::MODE_REMOVE, 12345, 0);
        push_op(sle_pkg::MODE_SEARCH, 32'sh7fff_ffff, 0);
        // zero limit refuses every insert
        push_ctrl(JOB_LIMIT, 0);
        push_op(sle_pkg::MODE_INSERT, 7, 0);
        // limit below the count keeps entries, refuses inserts until count drops
        push_ctrl(JOB_LIMIT, 2);
        push_op(sle_pkg::MODE_INSERT, 7, 0);
        push_op(sle_pkg::MODE_REMOVE, -1, 0);
        push_op(sle_pkg::MODE_REMOVE, 32'sh8000_0000, 0);
        push_op(sle_pkg::MODE_INSERT, 7, 0);
        push_op(sle_pkg::MODE_REMOVE, 32'sh7fff_ffff, 0);
        push_op(sle_pkg::MODE_INSERT, 8, 0);
        // limit above the capacity acts as the capacity
        push_ctrl(JOB_LIMIT, 31);
        push_op(sle_pkg::MODE_INSERT, 3, 0);
        push_op(sle_pkg::MODE_GET, 0, 1);

        // random phases, each under its own limit, with a drain in the middle
        for (ph = 0; ph < PHASES; ph++)
        begin
            push_ctrl(JOB_LIMIT, 5'(phase_limits[ph]));
            for (n = 0; n < PHASE_OPS; n++)
            begin
                if (n == PHASE_OPS / 2)
                    push_ctrl(JOB_DRAIN, 0);
                push_random((ph % 2) ? 50 : 30);
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (all_sent);
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
            note_mismatch("results never delivered", expected_results.size(), 0);

        $display("ran %0d transactions and %0d limit writes, %0d results checked",
                 accepted, limit_writes, result_count);
        $display("outcomes: ok %0d, full %0d, not found %0d, out of range %0d",
                 status_seen[sle_pkg::ST_OK], status_seen[sle_pkg::ST_FULL],
                 status_seen[sle_pkg::ST_NOT_FOUND], status_seen[sle_pkg::ST_RANGE]);
        if (fail_count == 0)
            $display("sorted_list_engine_core test passed");
        else
            $display("sorted_list_engine_core test failed");
        $finish;
    end

endmodule
